>>> rtl/wfg_pkg.sv
// shared types, constants and the quarter-wave table of the waveform generator
package wfg_pkg;

  localparam int TIME_W   = 32;
  localparam int PER_W    = 24;
  localparam int AMP_W    = 16;
  localparam int VOLT_W   = 16;
  localparam int MODE_W   = 2;
  localparam int MOD_STEPS = TIME_W;
  localparam int DIV_STEPS = VOLT_W;
  localparam int NUM_W    = PER_W + AMP_W;
  localparam int CFG_AW   = 4;

  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAW    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  localparam logic [CFG_AW-1:0] REG_WAVE_MODE = 4'h0;
  localparam logic [CFG_AW-1:0] REG_PERIOD    = 4'h4;
  localparam logic [CFG_AW-1:0] REG_AMPLITUDE = 4'h8;

  typedef struct packed {
    logic [PER_W-1:0]  rem;
    logic [TIME_W-1:0] dvd;
    logic [VOLT_W-1:0] aux;
  } wfg_step_t;

  function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
    logic [14:0] v;
    case (idx)
      6'd0:  v = 15'h0000; 6'd1:  v = 15'h0647; 6'd2:  v = 15'h0c8b; 6'd3:  v = 15'h12c7;
      6'd4:  v = 15'h18f8; 6'd5:  v = 15'h1f19; 6'd6:  v = 15'h2527; 6'd7:  v = 15'h2b1e;
      6'd8:  v = 15'h30fb; 6'd9:  v = 15'h36b9; 6'd10: v = 15'h3c56; 6'd11: v = 15'h41cd;
      6'd12: v = 15'h471c; 6'd13: v = 15'h4c3f; 6'd14: v = 15'h5133; 6'd15: v = 15'h55f4;
      6'd16: v = 15'h5a81; 6'd17: v = 15'h5ed6; 6'd18: v = 15'h62f1; 6'd19: v = 15'h66ce;
      6'd20: v = 15'h6a6c; 6'd21: v = 15'h6dc9; 6'd22: v = 15'h70e1; 6'd23: v = 15'h73b5;
      6'd24: v = 15'h7640; 6'd25: v = 15'h7883; 6'd26: v = 15'h7a7c; 6'd27: v = 15'h7c29;
      6'd28: v = 15'h7d89; 6'd29: v = 15'h7e9c; 6'd30: v = 15'h7f61; 6'd31: v = 15'h7fd7;
      default: v = 15'h7fff;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/wfg_div_stage.sv
// one registered restoring-division step with valid bit
module wfg_div_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [wfg_pkg::PER_W-1:0]  divisor,
  input  logic                       vld_in,
  input  wfg_pkg::wfg_step_t         step_in,
  output logic                       vld_out,
  output wfg_pkg::wfg_step_t         step_out
);
  import wfg_pkg::*;

  logic [PER_W:0]  trial;
  logic            ge;
  wfg_step_t       step_nxt;
  logic            vld_r;
  wfg_step_t       step_r;

  always_comb begin
    trial = {step_in.rem, step_in.dvd[TIME_W-1]};
    ge = trial >= {1'b0, divisor};
    step_nxt.rem = ge ? PER_W'(trial - {1'b0, divisor}) : trial[PER_W-1:0];
    step_nxt.dvd = {step_in.dvd[TIME_W-2:0], ge};
    step_nxt.aux = step_in.aux;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign step_out = step_r;
endmodule

>>> rtl/waveform_function_generator_core.sv
// top level of the waveform generator: phase, scaling and sine pipeline
//
// channel | dir | fields
// in_     | in  | tdata[31:0] time_us
// out_    | out | tdata[15:0] voltage_mv
// cfg_    | in  | wave_mode @0x0, period @0x4, amplitude_mv @0x8
//
// one item per cycle unless held; stages: 32 modulo steps, one multiply,
// 16 quotient steps, two sine stages, input and output registers
// the whole pipeline holds while out_tvalid is high and out_tready low
// reset clears the valid bits and the configuration registers
module waveform_function_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // time_us
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // voltage_mv
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wfg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import wfg_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [PER_W-1:0]  per_r;
  logic [AMP_W-1:0]  amp_r;
  logic              en;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SQUARE;
      per_r  <= '0;
      amp_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        REG_WAVE_MODE: mode_r <= cfg_pwdata[MODE_W-1:0];
        REG_PERIOD:    per_r  <= cfg_pwdata[PER_W-1:0];
        REG_AMPLITUDE: amp_r  <= cfg_pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_WAVE_MODE: cfg_prdata = {{(32-MODE_W){1'b0}}, mode_r};
      REG_PERIOD:    cfg_prdata = {{(32-PER_W){1'b0}}, per_r};
      REG_AMPLITUDE: cfg_prdata = {{(32-AMP_W){1'b0}}, amp_r};
      default:       cfg_prdata = '0;
    endcase
  end

  logic out_vld_r;
  assign en         = !out_vld_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_vld_r;

  // modulo pipeline
  logic      mv [0:MOD_STEPS];
  wfg_step_t ms [0:MOD_STEPS];
  logic      in_vld_r;
  wfg_step_t in_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
    if (en) begin
      in_step_r.rem <= '0;
      in_step_r.dvd <= in_tdata;
      in_step_r.aux <= '0;
    end
  end

  assign mv[0] = in_vld_r;
  assign ms[0] = in_step_r;

  for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
    wfg_div_stage u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .divisor(per_r),
      .vld_in(mv[i]), .step_in(ms[i]), .vld_out(mv[i+1]), .step_out(ms[i+1])
    );
  end

  // multiply stage feeding the quotient pipeline
  logic [PER_W-1:0] phase;
  logic [NUM_W-1:0] num;
  logic             mul_vld_r;
  wfg_step_t        mul_step_r;

  always_comb begin
    phase = ms[MOD_STEPS].rem;
    if (mode_r == MODE_SINE) begin
      num = {1'b0, phase, 15'b0};
    end else begin
      num = phase * amp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= mv[MOD_STEPS];
    end
    if (en) begin
      mul_step_r.rem <= num[NUM_W-1:DIV_STEPS];
      mul_step_r.dvd <= {num[DIV_STEPS-1:0], {(TIME_W-DIV_STEPS){1'b0}}};
      mul_step_r.aux <= (phase <= (per_r >> 1)) ? amp_r : '0;
    end
  end

  logic      dv [0:DIV_STEPS];
  wfg_step_t ds [0:DIV_STEPS];
  assign dv[0] = mul_vld_r;
  assign ds[0] = mul_step_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    wfg_div_stage u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .divisor(per_r),
      .vld_in(dv[i]), .step_in(ds[i]), .vld_out(dv[i+1]), .step_out(ds[i+1])
    );
  end

  // sine interpolation
  logic [VOLT_W-1:0] quo;
  logic [6:0]        seg;
  logic [4:0]        idx;
  logic [7:0]        frac;
  logic [14:0]       base;
  logic [14:0]       nxt;
  logic [22:0]       slope;
  logic              a_vld_r;
  logic [14:0]       a_mag_r;
  logic              a_neg_r;
  logic [VOLT_W-1:0] a_sq_r;
  logic [VOLT_W-1:0] a_saw_r;

  always_comb begin
    quo   = ds[DIV_STEPS].dvd[VOLT_W-1:0];
    seg   = quo[14:8];
    idx   = seg[5] ? ~seg[4:0] : seg[4:0];
    frac  = seg[5] ? ~quo[7:0] : quo[7:0];
    base  = quarter_sine({1'b0, idx});
    nxt   = quarter_sine(6'({1'b0, idx} + 6'd1));
    slope = (nxt - base) * frac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= dv[DIV_STEPS];
    end
    if (en) begin
      a_mag_r <= 15'(base + slope[22:8]);
      a_neg_r <= seg[6];
      a_sq_r  <= ds[DIV_STEPS].aux;
      a_saw_r <= quo;
    end
  end

  // amplitude scaling
  logic [14:0]       half;
  logic [29:0]       sprod;
  logic              b_vld_r;
  logic [VOLT_W-1:0] b_sine_r;
  logic [VOLT_W-1:0] b_sq_r;
  logic [VOLT_W-1:0] b_saw_r;

  always_comb begin
    half  = amp_r[AMP_W-1:1];
    sprod = half * a_mag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
    if (en) begin
      b_sine_r <= a_neg_r ? VOLT_W'({1'b0, half} - {1'b0, sprod[29:15]})
                          : VOLT_W'({1'b0, half} + {1'b0, sprod[29:15]});
      b_sq_r   <= a_sq_r;
      b_saw_r  <= a_saw_r;
    end
  end

  // result select
  logic [VOLT_W-1:0] volt_nxt;
  logic [VOLT_W-1:0] volt_r;

  always_comb begin
    if (mode_r == MODE_NONE) begin
      volt_nxt = '0;
    end else if (per_r == '0) begin
      volt_nxt = amp_r;
    end else begin
      unique case (mode_r)
        MODE_SQUARE: volt_nxt = b_sq_r;
        MODE_SAW:    volt_nxt = b_saw_r;
        MODE_SINE:   volt_nxt = b_sine_r;
        default:     volt_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= b_vld_r;
    end
    if (en) begin
      volt_r <= volt_nxt;
    end
  end

  assign out_tdata = volt_r;
endmodule

>>> rtl/wfg_checker.sv
// port-level checks of the waveform generator
module wfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline held");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("config port not ready");
endmodule

bind waveform_function_generator_core wfg_checker u_wfg_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .cfg_pready(cfg_pready)
);
